// ===== src/i2c_eeprom_byte_master_macros.svh =====
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_macros
// Assertion macros used by the bus engine of the EEPROM byte master.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_MASTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IEBM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IEBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iebm_pkg.sv =====
// ----------------------------------------------------------------------------
// iebm_pkg
// Types and constants of the serial EEPROM byte master.
// ----------------------------------------------------------------------------
`default_nettype none

package iebm_pkg;

  localparam int ADDR_W        = 11;
  localparam int ADDR_BITS_DEF = 11;
  localparam int HALF_W        = 16;
  localparam int TMO_W         = 10;
  localparam int WAIT_W        = 24;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 16;

  // Input tdata layout
  localparam int ACTION_LSB = 0;
  localparam int ADDR_LSB   = 2;
  localparam int DATA_LSB   = 13;
  localparam int SDA_LSB    = 21;

  localparam logic [1:0] ACTION_READ  = 2'd1;
  localparam logic [1:0] ACTION_WRITE = 2'd2;

  localparam logic [7:0] CTRL_WRITE = 8'hA0;
  localparam logic [7:0] CTRL_READ  = 8'hA1;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [TMO_W-1:0]  ACK_TIMEOUT_RST = 10'd250;
  localparam logic [WAIT_W-1:0] WRITE_WAIT_RST  = 24'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_ACK_TIMEOUT = 2'd1,
    CFG_WRITE_WAIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_HI,
    PH_START_LO,
    PH_RS_PRE,
    PH_RS_HI,
    PH_RS_LO,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_NACK_LOW,
    PH_NACK_HIGH,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C,
    PH_WRITE_WAIT,
    PH_BIT_LO,
    PH_BIT_HI,
    PH_ACK_LO,
    PH_ACK_HI
  } phase_t;

  typedef enum logic [1:0] {
    BYTE_CTRL_WR = 2'd0,
    BYTE_ADDR_LO = 2'd1,
    BYTE_DATA    = 2'd2,
    BYTE_CTRL_RD = 2'd3
  } byte_sel_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              sda;
  } item_t;

  // Packed so that scl sits in the lowest bit.
  typedef struct packed {
    logic       ack_error;
    logic [7:0] read_value;
    logic       done;
    logic       busy;
    logic       sda_low;
    logic       scl;
  } result_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period;
    logic [TMO_W-1:0]  ack_timeout;
    logic [WAIT_W-1:0] write_wait;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/i2c_eeprom_byte_master.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// Two-wire master for small serial EEPROMs: byte write and random read.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick carrying the sampled SDA level and
// an optional read or write command; each tick yields exactly one result
// transaction with the SCL/SDA drive levels, busy, done, the last read byte
// and the ack error flag after that tick. The block sustains one tick per
// clock cycle when both sides flow: a two-entry input queue feeds the bus
// sequencer, which retires one tick per cycle into an output register, so
// each tick is held in a queue slot and then in the output register. Commands
// arriving while a transaction is under way are ignored. Configuration writes
// take effect on the next tick and are meant for idle periods only.
`default_nettype none

module i2c_eeprom_byte_master
  import iebm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [1:0] action, [12:2] addr, [20:13] data, [21] sda_in, [23:22] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [0] scl, [1] sda_low, [2] busy_res, [3] done_res, [11:4] read_value,
  // [12] ack_error, [15:13] zero
  output logic [M_TDATA_W-1:0]      m_tdata,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= HALF_PERIOD_RST;
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
      cfg.write_wait  <= WRITE_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HALF_PERIOD: cfg.half_period <= cfg_wdata[HALF_W-1:0];
        CFG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_wdata[TMO_W-1:0];
        CFG_WRITE_WAIT:  cfg.write_wait  <= cfg_wdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  iebm_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  iebm_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ===== src/iebm_front.sv =====
// ----------------------------------------------------------------------------
// iebm_front
// Accepts tick transactions, classifies the action and queues them in a
// two-entry buffer for the bus engine.
// ----------------------------------------------------------------------------
`default_nettype none

module iebm_front
  import iebm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output item_t                     item,
  output logic                      item_valid,
  input  wire logic                 item_pop
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      in_item;
  logic [1:0] action;

  assign action = s_tdata[ACTION_LSB +: 2];

  always_comb begin
    case (action)
      ACTION_READ:  in_item.cmd = CMD_READ;
      ACTION_WRITE: in_item.cmd = CMD_WRITE;
      default:      in_item.cmd = CMD_TICK;
    endcase
    // drop address bits the device does not decode
    in_item.addr = ADDR_W'(s_tdata[ADDR_LSB +: ADDR_BITS]);
    in_item.data = s_tdata[DATA_LSB +: 8];
    in_item.sda  = s_tdata[SDA_LSB];
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/iebm_engine.sv =====
// ----------------------------------------------------------------------------
// iebm_engine
// Bus sequencer: one tick per queued item, drives SCL/SDA and holds the
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_eeprom_byte_master_macros.svh"

module iebm_engine
  import iebm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire item_t                item,
  input  wire logic                 item_valid,
  output logic                      item_pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata
);

  phase_t                phase, phase_next;
  byte_sel_t             byte_sel, byte_sel_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [WAIT_W-1:0]     wait_count, wait_count_next;
  logic [TMO_W-1:0]      poll_count, poll_count_next;
  logic [ADDR_BITS-1:0]  held_addr, held_addr_next;
  logic [7:0]            held_data, held_data_next;
  logic                  is_read, is_read_next;
  logic                  error_flag, error_flag_next;
  logic [7:0]            last_read, last_read_next;
  logic                  done_next;
  result_t               result, result_next;

  logic                  fire;
  logic [HALF_W-1:0]     hp_eff;
  logic                  half_done;
  logic [WAIT_W-1:0]     wait_inc;
  logic                  enter_en;
  phase_t                enter_phase;
  logic                  load_en;
  byte_sel_t             load_sel;
  logic [ADDR_W-1:0]     addr_ext;
  logic [7:0]            load_byte;
  logic [7:0]            rx_shift;
  logic [3:0]            bit_inc;
  logic [1:0]            lines;

  // Line levels {scl, sda released} shown in each phase.
  function automatic logic [1:0] phase_lines(phase_t ph, logic bit_out);
    logic [1:0] lv;
    case (ph)
      PH_BIT_LO:                          lv = {1'b0, bit_out};
      PH_BIT_HI:                          lv = {1'b1, bit_out};
      PH_ACK_LO:                          lv = 2'b01;
      PH_START_LO, PH_RS_LO:              lv = 2'b10;
      PH_RS_PRE, PH_RX_LOW, PH_NACK_LOW:  lv = 2'b01;
      PH_STOP_A:                          lv = 2'b00;
      PH_STOP_B:                          lv = 2'b10;
      default:                            lv = 2'b11;
    endcase
    return lv;
  endfunction

  assign fire     = item_valid && (!m_tvalid || m_tready);
  assign item_pop = fire;

  assign hp_eff    = (cfg.half_period == '0) ? HALF_W'(1) : cfg.half_period;
  assign half_done = ({1'b0, wait_count} + 25'd1) >= {9'b0, hp_eff};
  assign wait_inc  = wait_count + WAIT_W'(1);
  assign bit_inc   = bit_index + 4'd1;
  assign rx_shift  = {shift_byte[6:0], item.sda};
  assign addr_ext  = ADDR_W'(held_addr_next);

  always_comb begin
    case (load_sel)
      BYTE_CTRL_WR: load_byte = CTRL_WRITE | {4'b0, addr_ext[10:8], 1'b0};
      BYTE_ADDR_LO: load_byte = addr_ext[7:0];
      BYTE_DATA:    load_byte = held_data_next;
      default:      load_byte = CTRL_READ;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    byte_sel_next   = byte_sel;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    wait_count_next = wait_count;
    poll_count_next = poll_count;
    held_addr_next  = held_addr;
    held_data_next  = held_data;
    is_read_next    = is_read;
    error_flag_next = error_flag;
    last_read_next  = last_read;
    done_next       = 1'b0;
    enter_en        = 1'b0;
    enter_phase     = phase;
    load_en         = 1'b0;
    load_sel        = byte_sel;

    if (!half_done) begin
      wait_count_next = wait_inc;
    end

    case (phase)
      PH_IDLE: begin
        wait_count_next = wait_count;
        if (item.cmd == CMD_READ || item.cmd == CMD_WRITE) begin
          held_addr_next  = item.addr[ADDR_BITS-1:0];
          held_data_next  = item.data;
          is_read_next    = (item.cmd == CMD_READ);
          error_flag_next = 1'b0;
          enter_en        = 1'b1;
          enter_phase     = PH_START_HI;
        end
      end
      PH_START_HI: begin
        enter_en    = half_done;
        enter_phase = PH_START_LO;
      end
      PH_START_LO: begin
        load_en  = half_done;
        load_sel = BYTE_CTRL_WR;
      end
      PH_RS_PRE: begin
        enter_en    = half_done;
        enter_phase = PH_RS_HI;
      end
      PH_RS_HI: begin
        enter_en    = half_done;
        enter_phase = PH_RS_LO;
      end
      PH_RS_LO: begin
        load_en  = half_done;
        load_sel = BYTE_CTRL_RD;
      end
      PH_BIT_LO: begin
        enter_en    = half_done;
        enter_phase = PH_BIT_HI;
      end
      PH_BIT_HI: begin
        if (half_done) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_inc;
          enter_en        = 1'b1;
          enter_phase     = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
        end
      end
      PH_ACK_LO: begin
        enter_en    = half_done;
        enter_phase = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        wait_count_next = wait_count;
        if (!item.sda) begin
          case (byte_sel)
            BYTE_CTRL_WR: begin
              load_en  = 1'b1;
              load_sel = BYTE_ADDR_LO;
            end
            BYTE_ADDR_LO: begin
              if (is_read) begin
                enter_en    = 1'b1;
                enter_phase = PH_RS_PRE;
              end else begin
                load_en  = 1'b1;
                load_sel = BYTE_DATA;
              end
            end
            BYTE_DATA: begin
              enter_en    = 1'b1;
              enter_phase = PH_STOP_A;
            end
            default: begin
              bit_index_next  = 4'd0;
              shift_byte_next = 8'd0;
              enter_en        = 1'b1;
              enter_phase     = PH_RX_LOW;
            end
          endcase
        end else if (poll_count >= cfg.ack_timeout) begin
          // timed out: release the bus with a stop and flag it
          error_flag_next = 1'b1;
          enter_en        = 1'b1;
          enter_phase     = PH_STOP_A;
        end else begin
          poll_count_next = poll_count + TMO_W'(1);
        end
      end
      PH_RX_LOW: begin
        enter_en    = half_done;
        enter_phase = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        // sample on the first tick after SCL rises
        if (wait_count == '0) begin
          shift_byte_next = rx_shift;
        end
        if (half_done) begin
          bit_index_next = bit_inc;
          enter_en       = 1'b1;
          if (bit_inc >= 4'd8) begin
            last_read_next = shift_byte_next;
            enter_phase    = PH_NACK_LOW;
          end else begin
            enter_phase = PH_RX_LOW;
          end
        end
      end
      PH_NACK_LOW: begin
        enter_en    = half_done;
        enter_phase = PH_NACK_HIGH;
      end
      PH_NACK_HIGH: begin
        enter_en    = half_done;
        enter_phase = PH_STOP_A;
      end
      PH_STOP_A: begin
        enter_en    = half_done;
        enter_phase = PH_STOP_B;
      end
      PH_STOP_B: begin
        enter_en    = half_done;
        enter_phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        if (half_done) begin
          enter_en = 1'b1;
          if (!is_read && !error_flag && cfg.write_wait != '0) begin
            enter_phase = PH_WRITE_WAIT;
          end else begin
            enter_phase = PH_IDLE;
            done_next   = 1'b1;
          end
        end
      end
      PH_WRITE_WAIT: begin
        wait_count_next = wait_inc;
        if (wait_inc >= cfg.write_wait) begin
          enter_en    = 1'b1;
          enter_phase = PH_IDLE;
          done_next   = 1'b1;
        end
      end
      default: begin
        enter_en    = 1'b1;
        enter_phase = PH_IDLE;
      end
    endcase

    if (load_en) begin
      shift_byte_next = load_byte;
      bit_index_next  = 4'd0;
      byte_sel_next   = load_sel;
      enter_en        = 1'b1;
      enter_phase     = PH_BIT_LO;
    end

    if (enter_en) begin
      phase_next      = enter_phase;
      wait_count_next = '0;
      poll_count_next = '0;
    end
  end

  assign lines = phase_lines(phase_next, shift_byte_next[7]);

  always_comb begin
    result_next.scl        = lines[1];
    result_next.sda_low    = ~lines[0];
    result_next.busy       = (phase_next != PH_IDLE);
    result_next.done       = done_next;
    result_next.read_value = last_read_next;
    result_next.ack_error  = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_sel   <= BYTE_CTRL_WR;
      bit_index  <= '0;
      shift_byte <= '0;
      wait_count <= '0;
      poll_count <= '0;
      held_addr  <= '0;
      held_data  <= '0;
      is_read    <= 1'b0;
      error_flag <= 1'b0;
      last_read  <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      byte_sel   <= byte_sel_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      wait_count <= wait_count_next;
      poll_count <= poll_count_next;
      held_addr  <= held_addr_next;
      held_data  <= held_data_next;
      is_read    <= is_read_next;
      error_flag <= error_flag_next;
      last_read  <= last_read_next;
    end
  end

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign m_tdata = {(M_TDATA_W - $bits(result_t))'(0), result};

  `IEBM_ASSERT_NEXT(a_fire_shows_result, clk, rst, fire, m_tvalid,
    "processed tick did not produce a result")
  `IEBM_ASSERT_NEXT(a_done_returns_idle, clk, rst, fire && done_next,
    phase == PH_IDLE && result.done && !result.busy,
    "done pulse without return to idle")
  `IEBM_ASSERT_IMPLIES(a_bit_index_range, clk, rst, 1'b1, bit_index <= 4'd8,
    "bit counter ran past one byte")

endmodule

`default_nettype wire
